FILE: sv/so3em_pkg.sv
// Package: fixed-point constants and the arctangent table for the SO(3) exponential map.
`timescale 1ns / 1ps

package so3em_pkg;

    localparam int IN_W       = 32;
    localparam int WORD_W     = 32;
    localparam int SUM_W      = 48;
    localparam int ANG_W      = 36;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int NUM_PAIRS  = 6;
    localparam int NUM_OUT    = 9;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam logic [63:0] SMALL_T2_LIMIT = 64'd8;

    localparam logic signed [ANG_W-1:0] PI_Q30          = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30     = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30      = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] FOUR_PI_Q30     = 36'sd13493037704;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_INV = 36'sd652032874;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -48'sd2147483648;

    // pair order: 00, 11, 22, 01, 02, 12
    localparam int PAIR_I [NUM_PAIRS] = '{0, 1, 2, 0, 0, 1};
    localparam int PAIR_J [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] a;
        case (idx)
            0:       a = 32'h3243F6A8;
            1:       a = 32'h1DAC6705;
            2:       a = 32'h0FADBAFC;
            3:       a = 32'h07F56EA6;
            4:       a = 32'h03FEAB76;
            5:       a = 32'h01FFD55B;
            6:       a = 32'h00FFFAAA;
            7:       a = 32'h007FFF55;
            8:       a = 32'h003FFFEA;
            9:       a = 32'h001FFFFD;
            10:      a = 32'h000FFFFF;
            11:      a = 32'h0007FFFF;
            12:      a = 32'h0003FFFF;
            13:      a = 32'h0001FFFF;
            14:      a = 32'h0000FFFF;
            15:      a = 32'h00007FFF;
            16:      a = 32'h00003FFF;
            17:      a = 32'h00001FFF;
            18:      a = 32'h00000FFF;
            19:      a = 32'h000007FF;
            20:      a = 32'h000003FF;
            21:      a = 32'h000001FF;
            22:      a = 32'h000000FF;
            23:      a = 32'h0000007F;
            24:      a = 32'h0000003F;
            25:      a = 32'h0000001F;
            26:      a = 32'h0000000F;
            27:      a = 32'h00000008;
            28:      a = 32'h00000004;
            29:      a = 32'h00000002;
            30:      a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    function automatic logic [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[WORD_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/so3_exponential_map.sv
// Top level: pipelined SO(3) exponential map, rotation vector to rotation matrix.
`timescale 1ns / 1ps

// Takes one rotation vector (x, y, z, Q4.28) per cycle and returns the 3x3 rotation
// matrix (Q2.30, row by row) by Rodrigues' formula, or by the second-order series when
// the squared length is below 2^-53. The pipeline has one multiply stage, one sum
// stage, 32 square-root stages, 33 divider stages for the unit vector, two
// angle-reduction stages, one quadrant fold stage, CORDIC_STEPS CORDIC stages and four
// stages of matrix assembly ending in the output register. A stall on the result side
// holds the whole pipeline; throughput is one request per cycle.
module so3_exponential_map #(
    parameter int CORDIC_STEPS = 28
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // rot_vec_x, rot_vec_y, rot_vec_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

    localparam int SQ = so3em_pkg::SQRT_STEPS;
    localparam int DV = so3em_pkg::DIV_STEPS;
    localparam int CS = CORDIC_STEPS;
    localparam int AW = so3em_pkg::ANG_W;
    localparam int SW = so3em_pkg::SUM_W;
    localparam int NP = so3em_pkg::NUM_PAIRS;
    localparam int NO = so3em_pkg::NUM_OUT;

    logic adv;
    logic signed [31:0] s_v [3];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_v[k] = signed'(s_tdata[32*k +: 32]);
        end
    end

    // multiply stage
    logic               a_vld_reg;
    logic signed [31:0] a_v_reg [3];
    logic [63:0]        a_sq_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                a_v_reg[k]  <= s_v[k];
                a_sq_reg[k] <= s_v[k] * s_v[k];
            end
        end
    end

    // square root pipeline; element 0 holds t2
    logic               sq_vld_reg   [0:SQ];
    logic               sq_small_reg [0:SQ];
    logic signed [31:0] sq_v_reg     [0:SQ][3];
    logic [63:0]        sq_n_reg     [0:SQ];
    logic [63:0]        sq_res_reg   [0:SQ];
    logic [63:0]        t2_sum;

    assign t2_sum = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_small_reg[0] <= t2_sum < so3em_pkg::SMALL_T2_LIMIT;
            sq_v_reg[0]     <= a_v_reg;
            sq_n_reg[0]     <= t2_sum;
            sq_res_reg[0]   <= 64'd0;
        end
    end

    for (genvar i = 0; i < SQ; i++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * i);
        logic [64:0] trial;

        assign trial = {1'b0, sq_res_reg[i]} + {1'b0, SQ_BIT};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_small_reg[i+1] <= sq_small_reg[i];
                sq_v_reg[i+1]     <= sq_v_reg[i];
                if ({1'b0, sq_n_reg[i]} >= trial) begin
                    sq_n_reg[i+1]   <= sq_n_reg[i] - trial[63:0];
                    sq_res_reg[i+1] <= (sq_res_reg[i] >> 1) + SQ_BIT;
                end else begin
                    sq_n_reg[i+1]   <= sq_n_reg[i];
                    sq_res_reg[i+1] <= sq_res_reg[i] >> 1;
                end
            end
        end
    end

    // unit vector divider: |v| * 2^30 / t, one quotient bit per stage
    logic               dv_vld_reg   [0:DV];
    logic               dv_small_reg [0:DV];
    logic signed [31:0] dv_v_reg     [0:DV][3];
    logic [31:0]        dv_t_reg     [0:DV];
    logic [32:0]        dv_rem_reg   [0:DV][3];
    logic [31:0]        dv_low_reg   [0:DV][3];
    logic [31:0]        dv_q_reg     [0:DV][3];
    logic               dv_neg_reg   [0:DV][3];
    logic [31:0]        v_mag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v_mag[k] = sq_v_reg[SQ][k][31] ? 32'(-sq_v_reg[SQ][k]) : 32'(sq_v_reg[SQ][k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= sq_vld_reg[SQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_small_reg[0] <= sq_small_reg[SQ];
            dv_v_reg[0]     <= sq_v_reg[SQ];
            dv_t_reg[0]     <= sq_res_reg[SQ][31:0];
            for (int k = 0; k < 3; k++) begin
                dv_rem_reg[0][k] <= {3'b000, v_mag[k][31:2]};
                dv_low_reg[0][k] <= {v_mag[k][1:0], 30'd0};
                dv_q_reg[0][k]   <= 32'd0;
                dv_neg_reg[0][k] <= sq_v_reg[SQ][k][31];
            end
        end
    end

    for (genvar i = 0; i < DV; i++) begin : g_div
        logic [32:0] rem_sh [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                rem_sh[k] = {dv_rem_reg[i][k][31:0], dv_low_reg[i][k][31]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_small_reg[i+1] <= dv_small_reg[i];
                dv_v_reg[i+1]     <= dv_v_reg[i];
                dv_t_reg[i+1]     <= dv_t_reg[i];
                for (int k = 0; k < 3; k++) begin
                    dv_low_reg[i+1][k] <= dv_low_reg[i][k] << 1;
                    dv_neg_reg[i+1][k] <= dv_neg_reg[i][k];
                    if (rem_sh[k] >= {1'b0, dv_t_reg[i]}) begin
                        dv_rem_reg[i+1][k] <= rem_sh[k] - {1'b0, dv_t_reg[i]};
                        dv_q_reg[i+1][k]   <= {dv_q_reg[i][k][30:0], 1'b1};
                    end else begin
                        dv_rem_reg[i+1][k] <= rem_sh[k];
                        dv_q_reg[i+1][k]   <= {dv_q_reg[i][k][30:0], 1'b0};
                    end
                end
            end
        end
    end

    // angle reduction: t (as Q30) modulo 2*pi
    logic                 r1_vld_reg, r2_vld_reg;
    logic                 r1_small_reg, r2_small_reg;
    logic signed [31:0]   r1_v_reg [3];
    logic signed [31:0]   r2_v_reg [3];
    logic signed [31:0]   r1_u_reg [3];
    logic signed [31:0]   r2_u_reg [3];
    logic signed [AW-1:0] r1_a_reg, r2_a_reg;
    logic signed [AW-1:0] a_full;
    logic signed [31:0]   dv_u [3];

    assign a_full = signed'({2'b00, dv_t_reg[DV], 2'b00});

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv_u[k] = dv_neg_reg[DV][k] ? -signed'(dv_q_reg[DV][k]) : signed'(dv_q_reg[DV][k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end else if (adv) begin
            r1_vld_reg <= dv_vld_reg[DV];
            r2_vld_reg <= r1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_small_reg <= dv_small_reg[DV];
            r1_v_reg     <= dv_v_reg[DV];
            r1_u_reg     <= dv_u;
            r1_a_reg     <= (a_full >= so3em_pkg::FOUR_PI_Q30) ?
                            a_full - so3em_pkg::FOUR_PI_Q30 : a_full;
            r2_small_reg <= r1_small_reg;
            r2_v_reg     <= r1_v_reg;
            r2_u_reg     <= r1_u_reg;
            r2_a_reg     <= (r1_a_reg >= so3em_pkg::TWO_PI_Q30) ?
                            r1_a_reg - so3em_pkg::TWO_PI_Q30 : r1_a_reg;
        end
    end

    // CORDIC pipeline; element 0 holds the folded angle
    logic                 cr_vld_reg   [0:CS];
    logic                 cr_small_reg [0:CS];
    logic                 cr_neg_reg   [0:CS];
    logic signed [31:0]   cr_v_reg     [0:CS][3];
    logic signed [31:0]   cr_u_reg     [0:CS][3];
    logic signed [AW-1:0] cr_x_reg     [0:CS];
    logic signed [AW-1:0] cr_y_reg     [0:CS];
    logic signed [AW-1:0] cr_z_reg     [0:CS];
    logic signed [AW-1:0] fold_a, fold_b;
    logic                 fold_neg;

    always_comb begin
        fold_a   = (r2_a_reg > so3em_pkg::PI_Q30) ? r2_a_reg - so3em_pkg::TWO_PI_Q30 : r2_a_reg;
        fold_b   = fold_a;
        fold_neg = 1'b0;
        if (fold_a > so3em_pkg::HALF_PI_Q30) begin
            fold_b   = so3em_pkg::PI_Q30 - fold_a;
            fold_neg = 1'b1;
        end else if (fold_a < -so3em_pkg::HALF_PI_Q30) begin
            fold_b   = -so3em_pkg::PI_Q30 - fold_a;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            cr_vld_reg[0] <= r2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cr_small_reg[0] <= r2_small_reg;
            cr_neg_reg[0]   <= fold_neg;
            cr_v_reg[0]     <= r2_v_reg;
            cr_u_reg[0]     <= r2_u_reg;
            cr_x_reg[0]     <= so3em_pkg::CORDIC_GAIN_INV;
            cr_y_reg[0]     <= '0;
            cr_z_reg[0]     <= fold_b;
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        localparam logic signed [AW-1:0] ATAN = signed'(AW'(so3em_pkg::atan_q30(i)));
        logic signed [AW-1:0] xs, ys;

        assign xs = cr_x_reg[i] >>> i;
        assign ys = cr_y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cr_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                cr_vld_reg[i+1] <= cr_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cr_small_reg[i+1] <= cr_small_reg[i];
                cr_neg_reg[i+1]   <= cr_neg_reg[i];
                cr_v_reg[i+1]     <= cr_v_reg[i];
                cr_u_reg[i+1]     <= cr_u_reg[i];
                if (!cr_z_reg[i][AW-1]) begin
                    cr_x_reg[i+1] <= cr_x_reg[i] - ys;
                    cr_y_reg[i+1] <= cr_y_reg[i] + xs;
                    cr_z_reg[i+1] <= cr_z_reg[i] - ATAN;
                end else begin
                    cr_x_reg[i+1] <= cr_x_reg[i] + ys;
                    cr_y_reg[i+1] <= cr_y_reg[i] - xs;
                    cr_z_reg[i+1] <= cr_z_reg[i] + ATAN;
                end
            end
        end
    end

    // assembly stage 1: pair products and sin * u
    logic                 e1_vld_reg, e1_small_reg;
    logic signed [31:0]   e1_v_reg [3];
    logic signed [AW-1:0] e1_c_reg;
    logic signed [63:0]   e1_prod_reg [NP];
    logic signed [67:0]   e1_sprod_reg [3];
    logic signed [31:0]   opa [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            opa[k] = cr_small_reg[CS] ? cr_v_reg[CS][k] : cr_u_reg[CS][k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
        end else if (adv) begin
            e1_vld_reg <= cr_vld_reg[CS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_small_reg <= cr_small_reg[CS];
            e1_v_reg     <= cr_v_reg[CS];
            e1_c_reg     <= cr_neg_reg[CS] ? -cr_x_reg[CS] : cr_x_reg[CS];
            for (int p = 0; p < NP; p++) begin
                e1_prod_reg[p] <= opa[so3em_pkg::PAIR_I[p]] * opa[so3em_pkg::PAIR_J[p]];
            end
            for (int k = 0; k < 3; k++) begin
                e1_sprod_reg[k] <= cr_y_reg[CS] * cr_u_reg[CS][k];
            end
        end
    end

    // assembly stage 2: series matrix, p terms, q terms, 1 - cos
    logic                 e2_vld_reg, e2_small_reg;
    logic signed [35:0]   e2_p_reg [NP];
    logic signed [35:0]   e2_q_reg [3];
    logic signed [35:0]   e2_omc_reg;
    logic signed [SW-1:0] e2_ser_reg [NO];
    logic signed [63:0]   ser_num [NP];
    logic signed [SW-1:0] ser_h [NP];
    logic signed [SW-1:0] k4 [3];
    logic signed [SW-1:0] ser_m [NO];

    always_comb begin
        ser_num[0] = -(e1_prod_reg[1] + e1_prod_reg[2]);
        ser_num[1] = -(e1_prod_reg[0] + e1_prod_reg[2]);
        ser_num[2] = -(e1_prod_reg[0] + e1_prod_reg[1]);
        for (int p = 3; p < NP; p++) begin
            ser_num[p] = e1_prod_reg[p];
        end
        for (int p = 0; p < NP; p++) begin
            ser_h[p] = SW'((ser_num[p] + 64'sd67108864) >>> 27);
        end
        for (int k = 0; k < 3; k++) begin
            k4[k] = SW'(e1_v_reg[k]) <<< 2;
        end
        ser_m[0] = SW'(so3em_pkg::ONE_Q30) + ser_h[0];
        ser_m[1] = ser_h[3] - k4[2];
        ser_m[2] = ser_h[4] + k4[1];
        ser_m[3] = ser_h[3] + k4[2];
        ser_m[4] = SW'(so3em_pkg::ONE_Q30) + ser_h[1];
        ser_m[5] = ser_h[5] - k4[0];
        ser_m[6] = ser_h[4] - k4[1];
        ser_m[7] = ser_h[5] + k4[0];
        ser_m[8] = SW'(so3em_pkg::ONE_Q30) + ser_h[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_vld_reg <= 1'b0;
        end else if (adv) begin
            e2_vld_reg <= e1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e2_small_reg <= e1_small_reg;
            e2_ser_reg   <= ser_m;
            e2_omc_reg   <= 36'(so3em_pkg::ONE_Q30 - e1_c_reg);
            for (int p = 0; p < NP; p++) begin
                e2_p_reg[p] <= 36'((e1_prod_reg[p] >>> 30) -
                                   ((p < 3) ? so3em_pkg::ONE_Q30 : 64'sd0));
            end
            for (int k = 0; k < 3; k++) begin
                e2_q_reg[k] <= 36'((e1_sprod_reg[k] + 68'sd536870912) >>> 30);
            end
        end
    end

    // assembly stage 3: (1 - cos) * p
    logic                 e3_vld_reg, e3_small_reg;
    logic signed [71:0]   e3_w_reg [NP];
    logic signed [35:0]   e3_q_reg [3];
    logic signed [SW-1:0] e3_ser_reg [NO];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e3_vld_reg <= 1'b0;
        end else if (adv) begin
            e3_vld_reg <= e2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e3_small_reg <= e2_small_reg;
            e3_q_reg     <= e2_q_reg;
            e3_ser_reg   <= e2_ser_reg;
            for (int p = 0; p < NP; p++) begin
                e3_w_reg[p] <= e2_omc_reg * e2_p_reg[p];
            end
        end
    end

    // assembly stage 4: round, add skew terms, saturate into the output register
    logic                 m_tvalid_reg;
    logic [287:0]         m_tdata_reg;
    logic signed [SW-1:0] w [NP];
    logic signed [SW-1:0] q [3];
    logic signed [SW-1:0] g [NO];
    logic [287:0]         m_tdata_next;

    always_comb begin
        for (int p = 0; p < NP; p++) begin
            w[p] = SW'((e3_w_reg[p] + 72'sd536870912) >>> 30);
        end
        for (int k = 0; k < 3; k++) begin
            q[k] = SW'(e3_q_reg[k]);
        end
        g[0] = SW'(so3em_pkg::ONE_Q30) + w[0];
        g[1] = w[3] - q[2];
        g[2] = w[4] + q[1];
        g[3] = w[3] + q[2];
        g[4] = SW'(so3em_pkg::ONE_Q30) + w[1];
        g[5] = w[5] - q[0];
        g[6] = w[4] - q[1];
        g[7] = w[5] + q[0];
        g[8] = SW'(so3em_pkg::ONE_Q30) + w[2];
        for (int n = 0; n < NO; n++) begin
            m_tdata_next[32*n +: 32] = so3em_pkg::sat_word(e3_small_reg ? e3_ser_reg[n] : g[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= e3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
